/* design/shortest_path_single_source_core_assert.svh */
// Assertion macros for the shortest path core.
// Depends on nothing; included by the top level.
`ifndef SHORTEST_PATH_SINGLE_SOURCE_CORE_ASSERT_SVH
`define SHORTEST_PATH_SINGLE_SOURCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define SPS_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define SPS_ASSERT_IMP(label, clk, rst, a, c)
`define SPS_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

/* design/sps_pkg.sv */
// Package for the shortest path core: sizes, codes and the unreached distance.
// Depends on nothing.
`default_nettype none
package sps_pkg;
   localparam int VERTICES_DEF  = 64;
   localparam int MAX_EDGES_DEF = 256;
   localparam int VW = 6;
   localparam int DW = 24;
   localparam int CW = 16;
   localparam logic [DW-1:0] DIST_INF = {DW{1'b1}};
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_RUN = 2'd1;
   localparam logic [1:0] OP_CLR = 2'd2;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
endpackage
`default_nettype wire

/* design/shortest_path_single_source_core.sv */
// Shortest path core: edge store, distance table and the run sequencer.
// Depends on sps_pkg, sps_ram and the assertion macro header.
//
// Edge items and clear items give their status result in the cycle after they
// are accepted. A run first writes the distance RAM for every vertex in use
// (one vertex a cycle). Each round then scans all vertices in use for the
// nearest unsettled one through the distance RAM read port and walks the whole
// edge store, with a read-modify-write of the target distance for each
// relaxation. A run ends with one result per vertex in use. The block accepts
// no item while an item is at work.
`default_nettype none
`include "shortest_path_single_source_core_assert.svh"
module shortest_path_single_source_core #(
   parameter int VERTICES  = sps_pkg::VERTICES_DEF,
   parameter int MAX_EDGES = sps_pkg::MAX_EDGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [5:0]  req_from_vertex,
   input  wire logic [5:0]  req_to_vertex,
   input  wire logic [15:0] req_edge_cost,
   input  wire logic [5:0]  req_source_vertex,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_vertex,
   output logic [23:0]      rsp_distance,
   output logic             rsp_reached,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import sps_pkg::*;
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int VAW = $clog2(VERTICES);
   localparam int NVW = $clog2(VERTICES + 1);
   localparam logic [ECW-1:0] EMAX = ECW'(MAX_EDGES);
   localparam logic [6:0] VMAX7 = 7'(VERTICES);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SCAN, S_SCAN_END, S_EDGE, S_EDGE_CHK, S_RD_T, S_WR_T,
      S_OUT_RD, S_OUT_WAIT, S_OUT, S_STAT
   } state_type;

   state_type        state_ff, state_in;
   logic [6:0]       nv_reg_ff, nv_reg_in;
   logic [ECW-1:0]   ecount_ff, ecount_in;
   logic [VERTICES-1:0] settled_ff, settled_in;
   logic [VAW-1:0]   idx_ff, idx_in;
   logic [VAW-1:0]   scan_ff, scan_in;
   logic             scan_v_ff, scan_v_in;
   logic [VAW-1:0]   best_ff, best_in;
   logic [DW-1:0]    bestd_ff, bestd_in;
   logic             found_ff, found_in;
   logic [ECW-1:0]   eidx_ff, eidx_in;
   logic [VW-1:0]    t_ff, t_in;
   logic [DW-1:0]    nd_ff, nd_in;
   logic [5:0]       rv_ff, rv_in;
   logic [DW-1:0]    rd_ff, rd_in;
   logic             rr_ff, rr_in;
   logic [1:0]       rs_ff, rs_in;
   logic             rl_ff, rl_in;

   logic [NVW-1:0]   nv;
   logic             e_we;
   logic [EAW-1:0]   e_waddr, e_raddr;
   logic [27:0]      e_wdata, e_rdata;
   logic             d_we;
   logic [VAW-1:0]   d_waddr, d_raddr;
   logic [DW-1:0]    d_wdata, d_rdata;
   logic [DW:0]      sum;

   always_comb begin
      if (nv_reg_ff == 7'd0) begin
         nv = NVW'(1);
      end else if (nv_reg_ff > VMAX7) begin
         nv = NVW'(VERTICES);
      end else begin
         nv = NVW'(nv_reg_ff);
      end
   end

   sps_ram #(.WIDTH(28), .DEPTH(1 << EAW)) u_edges (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata)
   );
   sps_ram #(.WIDTH(DW), .DEPTH(1 << VAW)) u_dist (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_raddr), .rdata(d_rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_prdata = {25'd0, nv_reg_ff};
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT) || (state_ff == S_STAT);
   assign rsp_vertex = rv_ff;
   assign rsp_distance = rd_ff;
   assign rsp_reached = rr_ff;
   assign rsp_status = rs_ff;
   assign rsp_last = rl_ff;
   assign sum = {1'b0, bestd_ff} + {{(DW+1-CW){1'b0}}, e_rdata[15:0]};

   always_comb begin
      state_in = state_ff;
      nv_reg_in = nv_reg_ff;
      ecount_in = ecount_ff;
      settled_in = settled_ff;
      idx_in = idx_ff;
      scan_in = scan_ff;
      scan_v_in = 1'b0;
      best_in = best_ff;
      bestd_in = bestd_ff;
      found_in = found_ff;
      eidx_in = eidx_ff;
      t_in = t_ff;
      nd_in = nd_ff;
      rv_in = rv_ff;
      rd_in = rd_ff;
      rr_in = rr_ff;
      rs_in = rs_ff;
      rl_in = rl_ff;
      e_we = 1'b0;
      e_waddr = ecount_ff[EAW-1:0];
      e_wdata = {req_from_vertex, req_to_vertex, req_edge_cost};
      e_raddr = eidx_ff[EAW-1:0];
      d_we = 1'b0;
      d_waddr = idx_ff;
      d_wdata = DIST_INF;
      d_raddr = scan_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         nv_reg_in = csr_pwdata[6:0];
      end
      case (state_ff)
         S_IDLE: begin
            rv_in = 6'd0; rd_in = '0; rr_in = 1'b0; rl_in = 1'b1; rs_in = ST_OK;
            if (req_valid) begin
               case (req_op)
                  OP_ADD: begin
                     state_in = S_STAT;
                     if ({1'b0, req_from_vertex} >= nv || {1'b0, req_to_vertex} >= nv) begin
                        rs_in = ST_RANGE;
                     end else if (ecount_ff >= EMAX) begin
                        rs_in = ST_FULL;
                     end else begin
                        e_we = 1'b1;
                        ecount_in = ecount_ff + ECW'(1);
                     end
                  end
                  OP_RUN: begin
                     if ({1'b0, req_source_vertex} >= nv) begin
                        rs_in = ST_RANGE;
                        state_in = S_STAT;
                     end else begin
                        best_in = VAW'(req_source_vertex);
                        idx_in = '0;
                        settled_in = '0;
                        state_in = S_INIT;
                     end
                  end
                  OP_CLR: begin
                     ecount_in = '0;
                     state_in = S_STAT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            d_we = 1'b1;
            d_wdata = (idx_ff == best_ff) ? '0 : DIST_INF;
            idx_in = idx_ff + VAW'(1);
            if ({1'b0, idx_ff} == NVW'(nv - NVW'(1))) begin
               scan_in = '0;
               scan_v_in = 1'b1;
               bestd_in = DIST_INF;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Read of vertex scan_ff-1 lands now; issue the next one.
            if (!scan_v_ff && !settled_ff[idx_ff] && d_rdata < bestd_ff) begin
               bestd_in = d_rdata;
               best_in = idx_ff;
               found_in = 1'b1;
            end
            idx_in = scan_ff;
            scan_v_in = 1'b0;
            if ({1'b0, scan_ff} == NVW'(nv - NVW'(1))) begin
               state_in = S_SCAN_END;
            end else begin
               scan_in = scan_ff + VAW'(1);
            end
         end
         S_SCAN_END: begin
            if (!settled_ff[idx_ff] && d_rdata < bestd_ff) begin
               bestd_in = d_rdata;
               best_in = idx_ff;
               found_in = 1'b1;
            end
            state_in = S_EDGE;
            eidx_in = '0;
         end
         S_EDGE: begin
            if (!found_ff) begin
               idx_in = '0;
               state_in = S_OUT_RD;
            end else begin
               settled_in[best_ff] = 1'b1;
               if (eidx_ff >= ecount_ff) begin
                  scan_in = '0;
                  scan_v_in = 1'b1;
                  bestd_in = DIST_INF;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EDGE_CHK;
               end
            end
         end
         S_EDGE_CHK: begin
            eidx_in = eidx_ff + ECW'(1);
            state_in = S_EDGE;
            if (e_rdata[27:22] == VW'(best_ff) && {1'b0, e_rdata[27:22]} < nv
                && {1'b0, e_rdata[21:16]} < nv) begin
               t_in = e_rdata[21:16];
               nd_in = sum[DW-1:0] > (DIST_INF - DW'(1)) || sum[DW] ?
                       DIST_INF - DW'(1) : sum[DW-1:0];
               state_in = S_RD_T;
            end
         end
         S_RD_T: begin
            d_raddr = VAW'(t_ff);
            state_in = S_WR_T;
         end
         S_WR_T: begin
            d_waddr = VAW'(t_ff);
            d_wdata = nd_ff;
            d_we = (nd_ff < d_rdata);
            state_in = S_EDGE;
         end
         S_OUT_RD: begin
            d_raddr = idx_ff;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            rv_in = 6'(idx_ff);
            rd_in = d_rdata;
            rr_in = (d_rdata != DIST_INF);
            rs_in = ST_OK;
            rl_in = ({1'b0, idx_ff} == NVW'(nv - NVW'(1)));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (rl_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + VAW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         S_STAT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nv_reg_ff <= 7'd64;
         ecount_ff <= '0;
         settled_ff <= '0;
         scan_v_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nv_reg_ff <= nv_reg_in;
         ecount_ff <= ecount_in;
         settled_ff <= settled_in;
         scan_v_ff <= scan_v_in;
         found_ff <= found_in;
      end
      idx_ff <= idx_in;
      scan_ff <= scan_in;
      best_ff <= best_in;
      bestd_ff <= bestd_in;
      eidx_ff <= eidx_in;
      t_ff <= t_in;
      nd_ff <= nd_in;
      rv_ff <= rv_in;
      rd_ff <= rd_in;
      rr_ff <= rr_in;
      rs_ff <= rs_in;
      rl_ff <= rl_in;
   end

   `SPS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, ecount_ff <= EMAX)
   `SPS_ASSERT_IMP(a_reach_dist, clock, reset, state_ff == S_OUT, rr_ff == (rd_ff != DIST_INF))
   `SPS_ASSERT_NXT(a_stat_done, clock, reset, state_ff == S_STAT && rsp_ready, req_ready)
endmodule
`default_nettype wire

/* design/sps_ram.sv */
// Generic single-port write, single-port read RAM with registered read.
// Depends on nothing.
`default_nettype none
module sps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
